FILE: hw/rtl/gn3d_pkg.sv
package gn3d_pkg;

  // Width of a lattice cell index and of a permutation entry.
  localparam int CELL_BITS = 8;
  localparam int COORD_BITS = 24;

  // Reference permutation; indices wrap at the table size.
  localparam logic [CELL_BITS-1:0] PERM [0:255] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  // Pipeline stage enables handed to the fade units (stages two to five).
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } gn3d_adv_t;

endpackage

FILE: hw/rtl/gradient_noise_3d.sv
// Three-dimensional gradient noise sampler.
// Input stream (s_tvalid/s_tready/s_tdata): one request per point, three signed
// 24-bit coordinates with FRAC_BITS fraction bits. The low eight bits of each
// integer part choose the lattice cell, the fraction the offset within it.
// Output stream (m_tvalid/m_tready/m_tdata): one noise sample per request, in
// request order, as an unsigned OUT_BITS-bit fraction saturated at full scale.
// The datapath is an eight-stage pipeline: the first stage splits the coordinates
// and makes the first permutation lookup, two more finish the hash, one forms the
// gradient dots and one holds them while the fade polynomial, running alongside
// over four multiply stages, finishes; then three stages blend along x, y and z,
// the last also scaling into the output register.
// m_tvalid rises when an accepted request's result reaches stage eight, the
// output register; throughput is one request per cycle while m_tready stays high.
// Each stage takes new data whenever it is empty or its successor advances, so
// a stalled receiver only holds the occupied stages and empty slots keep filling;
// s_tready drops only when all eight are full.
// Reset (rst, synchronous) empties the pipeline; the permutation is a constant
// table and needs no loading.
module gradient_noise_3d
  import gn3d_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int OUT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // coord_x [23:0], coord_y [47:24], coord_z [71:48]
  input  logic [3*COORD_BITS-1:0]        s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // noise_value [OUT_BITS-1:0], zero padded to whole bytes
  output logic [((OUT_BITS+7)/8)*8-1:0]  m_tdata
);

  localparam int NST = 8;
  localparam int OW = FRAC_BITS + 2;          // corner offsets
  localparam int MW = FRAC_BITS + 4;          // blended values
  localparam int DW = MW + 1;
  localparam int PW = DW + FRAC_BITS + 2;
  localparam int SW = MW + OUT_BITS + 1;
  localparam int TW = ((OUT_BITS + 7) / 8) * 8;
  localparam logic signed [OW-1:0] ONE_O = OW'(1) <<< FRAC_BITS;
  localparam logic signed [MW-1:0] ONE_M = MW'(1) <<< FRAC_BITS;
  localparam logic [SW-1:0] OUT_MAX = (SW'(1) << OUT_BITS) - SW'(1);

  function automatic logic signed [MW-1:0] mix(input logic signed [MW-1:0] lo,
                                              input logic signed [MW-1:0] hi,
                                              input logic [FRAC_BITS:0] w);
    logic signed [DW-1:0] d;
    logic signed [PW-1:0] p;
    d = DW'(hi) - DW'(lo);
    p = PW'(d) * PW'($signed({1'b0, w}));
    p = p + (PW'(1) <<< (FRAC_BITS - 1));
    return lo + MW'(p >>> FRAC_BITS);
  endfunction

  // Gradient select: low four hash bits pick two of the offsets and their signs.
  function automatic logic signed [MW-1:0] dot(input logic [3:0] sel,
                                              input logic signed [OW-1:0] ox,
                                              input logic signed [OW-1:0] oy,
                                              input logic signed [OW-1:0] oz);
    logic signed [OW-1:0] a;
    logic signed [OW-1:0] b;
    a = (sel < 4'd8) ? ox : oy;
    if (sel < 4'd4) begin
      b = oy;
    end else if (sel == 4'd12 || sel == 4'd14) begin
      b = ox;
    end else begin
      b = oz;
    end
    if (sel[0]) a = -a;
    if (sel[1]) b = -b;
    return MW'(a) + MW'(b);
  endfunction

  // Stage valid bits and advance enables.
  logic [NST:1] v;
  logic [NST:1] en;
  gn3d_adv_t    adv;

  always_comb begin
    en[NST] = !v[NST] || m_tready;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
    adv = '{s2: en[2], s3: en[3], s4: en[4], s5: en[5]};
  end

  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_tvalid;
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Coordinate split.
  logic [COORD_BITS-1:0] in_x, in_y, in_z;
  logic [31:0]           ext_x, ext_y, ext_z;
  logic [CELL_BITS-1:0]  cell_x, cell_y, cell_z;

  always_comb begin
    in_x = s_tdata[0 +: COORD_BITS];
    in_y = s_tdata[COORD_BITS +: COORD_BITS];
    in_z = s_tdata[2*COORD_BITS +: COORD_BITS];
    ext_x = {{(32-COORD_BITS){in_x[COORD_BITS-1]}}, in_x};
    ext_y = {{(32-COORD_BITS){in_y[COORD_BITS-1]}}, in_y};
    ext_z = {{(32-COORD_BITS){in_z[COORD_BITS-1]}}, in_z};
    cell_x = ext_x[FRAC_BITS +: CELL_BITS];
    cell_y = ext_y[FRAC_BITS +: CELL_BITS];
    cell_z = ext_z[FRAC_BITS +: CELL_BITS];
  end

  logic [FRAC_BITS-1:0] s1_fx, s1_fy, s1_fz, s2_fx, s2_fy, s2_fz, s3_fx, s3_fy, s3_fz;
  logic [CELL_BITS-1:0] s1_cy, s1_cz, s2_cz;
  logic [CELL_BITS-1:0] s1_hx [2];
  logic [CELL_BITS-1:0] s2_hy [4];
  logic [CELL_BITS-1:0] s3_code [8];
  logic signed [MW-1:0] s4_dot [8];
  logic signed [MW-1:0] s5_dot [8];
  logic signed [MW-1:0] s6_e [4];
  logic signed [MW-1:0] s7_f [2];
  logic [FRAC_BITS:0]   wx, wy, wz, s6_wy, s6_wz, s7_wz;
  logic [OUT_BITS-1:0]  noise;

  gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (.clk, .adv, .frac(s1_fx), .weight(wx));
  gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (.clk, .adv, .frac(s1_fy), .weight(wy));
  gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (.clk, .adv, .frac(s1_fz), .weight(wz));

  // Corner offsets: the far corner along an axis sees the fraction minus one.
  logic signed [OW-1:0] off_x [2];
  logic signed [OW-1:0] off_y [2];
  logic signed [OW-1:0] off_z [2];

  always_comb begin
    off_x[0] = OW'(s3_fx);
    off_y[0] = OW'(s3_fy);
    off_z[0] = OW'(s3_fz);
    off_x[1] = OW'(s3_fx) - ONE_O;
    off_y[1] = OW'(s3_fy) - ONE_O;
    off_z[1] = OW'(s3_fz) - ONE_O;
  end

  // Final blend, recentering and scaling to the output fraction.
  logic signed [MW-1:0] blend;
  logic [SW-1:0]        scaled;

  always_comb begin
    blend = mix(s7_f[0], s7_f[1], s7_wz) + ONE_M;
    if (blend < 0) blend = '0;
    scaled = ((SW'(blend) << OUT_BITS) + (SW'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
    if (scaled > OUT_MAX) scaled = OUT_MAX;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_fx <= in_x[FRAC_BITS-1:0];
      s1_fy <= in_y[FRAC_BITS-1:0];
      s1_fz <= in_z[FRAC_BITS-1:0];
      s1_cy <= cell_y;
      s1_cz <= cell_z;
      s1_hx[0] <= PERM[cell_x];
      s1_hx[1] <= PERM[cell_x + CELL_BITS'(1)];
    end
    if (en[2]) begin
      s2_fx <= s1_fx;
      s2_fy <= s1_fy;
      s2_fz <= s1_fz;
      s2_cz <= s1_cz;
      for (int j = 0; j < 4; j++) begin
        s2_hy[j] <= PERM[s1_hx[j[0]] + s1_cy + CELL_BITS'(j[1])];
      end
    end
    if (en[3]) begin
      s3_fx <= s2_fx;
      s3_fy <= s2_fy;
      s3_fz <= s2_fz;
      for (int k = 0; k < 8; k++) begin
        s3_code[k] <= PERM[s2_hy[k[1:0]] + s2_cz + CELL_BITS'(k[2])];
      end
    end
    if (en[4]) begin
      for (int k = 0; k < 8; k++) begin
        s4_dot[k] <= dot(s3_code[k][3:0], off_x[k[0]], off_y[k[1]], off_z[k[2]]);
      end
    end
    if (en[5]) begin
      s5_dot <= s4_dot;
    end
    if (en[6]) begin
      for (int m = 0; m < 4; m++) begin
        s6_e[m] <= mix(s5_dot[2*m], s5_dot[2*m+1], wx);
      end
      s6_wy <= wy;
      s6_wz <= wz;
    end
    if (en[7]) begin
      s7_f[0] <= mix(s6_e[0], s6_e[1], s6_wy);
      s7_f[1] <= mix(s6_e[2], s6_e[3], s6_wy);
      s7_wz <= s6_wz;
    end
    if (en[8]) begin
      noise <= scaled[OUT_BITS-1:0];
    end
  end

  assign m_tvalid = v[NST];
  assign m_tdata = TW'(noise);

`ifndef ASSERT_OFF
  // An empty slot anywhere in the pipeline lets a new request in.
  a_ready_on_bubble: assert property (@(posedge clk) disable iff (rst)
    !(&v) |-> s_tready) else $error("input stalled with an empty stage");

  // An accepted request always occupies the first stage next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v[1]) else $error("accepted request lost");

  // With the receiver taking data, a result in the blend stage moves to the output.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    m_tready && v[NST-1] |=> m_tvalid) else $error("result not forwarded");
`endif

endmodule

FILE: hw/rtl/gn3d_fade.sv
module gn3d_fade
  import gn3d_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  gn3d_adv_t            adv,
  input  logic [FRAC_BITS-1:0] frac,
  output logic [FRAC_BITS:0]   weight
);

  // Quintic fade 6t^5-15t^4+10t^3 in Horner form, one rounded product per stage.
  localparam int AW = FRAC_BITS + 6;
  localparam int PW = AW + FRAC_BITS + 2;
  localparam logic signed [AW-1:0] ONE = AW'(1) <<< FRAC_BITS;

  function automatic logic signed [AW-1:0] mulq(input logic signed [AW-1:0] a,
                                               input logic [FRAC_BITS-1:0] f);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'($signed({1'b0, f}));
    p = p + (PW'(1) <<< (FRAC_BITS - 1));
    return AW'(p >>> FRAC_BITS);
  endfunction

  logic signed [AW-1:0]  acc0;
  logic signed [AW-1:0]  acc4;
  logic signed [AW-1:0]  a2, a3, a4;
  logic [FRAC_BITS-1:0]  f2, f3, f4;

  always_comb begin
    acc0 = AW'($signed({1'b0, frac})) * AW'(6) - ONE * AW'(15);
    acc4 = mulq(a4, f4);
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      a2 <= mulq(acc0, frac) + ONE * AW'(10);
      f2 <= frac;
    end
    if (adv.s3) begin
      a3 <= mulq(a2, f2);
      f3 <= f2;
    end
    if (adv.s4) begin
      a4 <= mulq(a3, f3);
      f4 <= f3;
    end
    if (adv.s5) begin
      if (acc4 < 0) begin
        weight <= '0;
      end else if (acc4 > ONE) begin
        weight <= (FRAC_BITS+1)'(ONE);
      end else begin
        weight <= (FRAC_BITS+1)'(acc4);
      end
    end
  end

endmodule

FILE: sim/gradient_noise_3d_tb.sv
`timescale 1ns / 100ps

module gradient_noise_3d_tb;
  import gn3d_pkg::*;

  localparam int FRAC = 16;
  localparam int OUTB = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  // coord_x [23:0], coord_y [47:24], coord_z [71:48]
  logic [71:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  // noise_value [15:0]
  logic [15:0] m_tdata;

  // Probability, in percent, that the sender or the receiver idles in a cycle.
  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int quiet_cycles;
  logic [15:0] noise_queue[$];

  gradient_noise_3d #(.FRAC_BITS(FRAC), .OUT_BITS(OUTB)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Floor division by 2^FRAC; the arithmetic shift floors negative values.
  function automatic longint qfloor(longint v);
    return v >>> FRAC;
  endfunction

  // Product of two Q values, rounded to nearest with ties upward.
  function automatic longint qmul(longint a, longint b);
    return qfloor(a * b + (ONE >>> 1));
  endfunction

  // Quintic fade weight, clamped to [0, ONE].
  function automatic longint fade(longint f);
    longint acc;
    acc = 6 * f - 15 * ONE;
    acc = qmul(acc, f) + 10 * ONE;
    acc = qmul(acc, f);
    acc = qmul(acc, f);
    acc = qmul(acc, f);
    if (acc < 0) acc = 0;
    if (acc > ONE) acc = ONE;
    return acc;
  endfunction

  function automatic longint lerp(longint lo, longint hi, longint w);
    return lo + qmul(w, hi - lo);
  endfunction

  function automatic logic [7:0] hash3(logic [7:0] cx, logic [7:0] cy, logic [7:0] cz);
    logic [7:0] k;
    k = PERM[cx];
    k = PERM[k + cy];
    return PERM[k + cz];
  endfunction

  // Dot product of the hashed gradient direction with the corner offset.
  function automatic longint grad_dot(logic [7:0] code, longint ox, longint oy, longint oz);
    logic [3:0] sel;
    longint u, v;
    sel = code[3:0];
    u = (sel < 8) ? ox : oy;
    v = (sel < 4) ? oy : ((sel == 12 || sel == 14) ? ox : oz);
    return (sel[0] ? -u : u) + (sel[1] ? -v : v);
  endfunction

  function automatic logic [15:0] noise_of(logic [71:0] pt);
    logic [7:0] cx, cy, cz, nx, ny, nz;
    longint fx, fy, fz, gx, gy, gz, wx, wy, wz;
    longint e00, e10, e01, e11, f0, f1, b, sc;
    cx = pt[23:16]; cy = pt[47:40]; cz = pt[71:64];
    fx = longint'(pt[15:0]); fy = longint'(pt[39:24]); fz = longint'(pt[63:48]);
    nx = cx + 8'd1; ny = cy + 8'd1; nz = cz + 8'd1;
    gx = fx - ONE; gy = fy - ONE; gz = fz - ONE;
    wx = fade(fx); wy = fade(fy); wz = fade(fz);
    e00 = lerp(grad_dot(hash3(cx, cy, cz), fx, fy, fz),
               grad_dot(hash3(nx, cy, cz), gx, fy, fz), wx);
    e10 = lerp(grad_dot(hash3(cx, ny, cz), fx, gy, fz),
               grad_dot(hash3(nx, ny, cz), gx, gy, fz), wx);
    f0 = lerp(e00, e10, wy);
    e01 = lerp(grad_dot(hash3(cx, cy, nz), fx, fy, gz),
               grad_dot(hash3(nx, cy, nz), gx, fy, gz), wx);
    e11 = lerp(grad_dot(hash3(cx, ny, nz), fx, gy, gz),
               grad_dot(hash3(nx, ny, nz), gx, gy, gz), wx);
    f1 = lerp(e01, e11, wy);
    b = lerp(f0, f1, wz) + ONE;
    if (b < 0) b = 0;
    sc = ((b <<< OUTB) + ONE) >>> (FRAC + 1);
    if (sc > 65535) sc = 65535;
    return sc[15:0];
  endfunction

  // Sends one point and queues its expected noise value on acceptance.
  // s_tvalid stays high after acceptance so the next point can follow at once;
  // it is lowered only while the sender idles.
  task automatic send_point(logic [71:0] pt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    noise_queue.push_back(noise_of(pt));
  endtask

  // The receiver stalls at random and checks each sample against the oldest one queued.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (noise_queue.size() == 0) begin
          $display("%0t: unexpected sample, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          if (m_tdata !== noise_queue[0]) begin
            $display("%0t: noise_value mismatch, expected %h, actual %h",
                     $time, noise_queue[0], m_tdata);
            errors++;
          end
          void'(noise_queue.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (s_tvalid || noise_queue.size() != 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [71:0] pack_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    return {z, y, x};
  endfunction

  // Field extremes, cell wrap-around, negative coordinates, exact lattice points.
  task automatic test_directed();
    logic [23:0] edges[8];
    edges = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
              24'h010000, 24'hFF0000, 24'h00FFFF, 24'h008000};
    for (int i = 0; i < 8; i++)
      send_point(pack_point(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]));
    for (int i = 0; i < 8; i++)
      send_point(pack_point(edges[i], edges[i], edges[i]));
    // Points with fractions near one; the second has x at cell 255 so its neighbor wraps to cell 0.
    send_point(pack_point(24'h00FF80, 24'h00FF40, 24'h00FFC0));
    send_point(pack_point(24'hFFFF01, 24'h7F8001, 24'h80FFFF));
    // Probe points stepping across cells, with fractions spread over the cell.
    for (int i = 0; i < 6; i++)
      send_point(pack_point(24'(i * 24'h013333), 24'(24'h7FFFFF - i * 24'h011111),
                            24'(i * 24'h00A0A0)));
  endtask

  // Uniform random points, with some coordinates placed near a cell boundary.
  task automatic test_random(int count);
    logic [23:0] c[3];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++) begin
        c[k] = 24'($urandom());
        if ($urandom_range(3) == 0) c[k][15:0] = $urandom_range(1) ? 16'(
          $urandom_range(31)) : 16'(16'hFFFF - $urandom_range(31));
      end
      send_point(pack_point(c[0], c[1], c[2]));
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (noise_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    quiet_cycles = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    send_idle_pct = 32;
    recv_idle_pct = 53;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(180);
    send_idle_pct = 53;
    recv_idle_pct = 32;
    test_random(180);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(190);
    wait_drained();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
